[rtl/slir_pkg.sv]
// Package with the constants, codes and types shared by the sorted list files.
package slir_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic                    found;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

[rtl/slir_cell.sv]
// One entry cell of the sorted list chain with its compare and shift logic.
module slir_cell (
    input  logic                             i_clk,
    input  slir_pkg::t_cell_ctl              i_ctl,
    input  logic                             i_valid,
    input  logic                             i_left_key,
    input  logic signed [slir_pkg::VAL_W-1:0] i_left_val,
    input  logic signed [slir_pkg::VAL_W-1:0] i_right_val,
    output logic                             o_key,
    output logic                             o_eq,
    output logic signed [slir_pkg::VAL_W-1:0] o_val
);

    logic signed [slir_pkg::VAL_W-1:0] r_val;
    logic signed [slir_pkg::VAL_W-1:0] n_val;
    logic                              ge;
    logic                              rem_key;

    always_comb begin
        ge      = !(r_val < i_ctl.value);
        o_key   = !i_valid || ge;
        rem_key = i_valid && ge;
        o_eq    = i_valid && (r_val == i_ctl.value);
        n_val   = r_val;
        if (i_ctl.ins && o_key) begin
            n_val = i_left_key ? i_left_val : i_ctl.value;
        end else if (i_ctl.rem && i_ctl.found && rem_key) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

[rtl/sorted_list_insert_remove.sv]
// Top level of the sorted list: the cell chain, the entry count and the result register.
// The result of each item appears in the output register on the next cycle.
// An item is taken every cycle while the result register is empty or being drained.
// All cells compare against the item value at once and shift by one place in that cycle.
// Synchronous active-low reset empties the list and the result register; entries are not cleared.
module sorted_list_insert_remove (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic signed [slir_pkg::VAL_W-1:0] i_value,
    input  logic [3:0]                        i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [slir_pkg::VAL_W-1:0] o_read_value,
    output logic [4:0]                        o_entry_count
);

    localparam int N = slir_pkg::CAPACITY;

    logic [slir_pkg::CNT_W-1:0]        r_count;
    logic [slir_pkg::CNT_W-1:0]        n_count;
    logic                              r_out_valid;
    logic [1:0]                        r_status;
    logic [1:0]                        n_status;
    logic signed [slir_pkg::VAL_W-1:0] r_read_value;
    logic signed [slir_pkg::VAL_W-1:0] n_read_value;

    logic                              accept;
    logic                              full;
    logic                              found;
    slir_pkg::t_cell_ctl               ctl;
    logic [N-1:0]                      key;
    logic [N-1:0]                      eq;
    logic [N-1:0]                      valid;
    logic signed [slir_pkg::VAL_W-1:0] val [N];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = 32'(r_count) >= 32'(N);
    assign found      = |eq;

    always_comb begin
        ctl.ins   = accept && (i_opcode == slir_pkg::OP_INSERT) && !full;
        ctl.rem   = accept && (i_opcode == slir_pkg::OP_REMOVE);
        ctl.found = found;
        ctl.value = i_value;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign valid[g] = 32'(g) < 32'(r_count);
            slir_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (valid[g]),
                .i_left_key  ((g == 0) ? 1'b0 : key[(g == 0) ? 0 : g - 1]),
                .i_left_val  (val[(g == 0) ? 0 : g - 1]),
                .i_right_val (val[(g == N - 1) ? g : g + 1]),
                .o_key       (key[g]),
                .o_eq        (eq[g]),
                .o_val       (val[g])
            );
        end
    endgenerate

    always_comb begin
        n_count      = r_count;
        n_status     = slir_pkg::ST_OK;
        n_read_value = '0;
        case (i_opcode)
            slir_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = slir_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            slir_pkg::OP_REMOVE: begin
                if (found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = slir_pkg::ST_NOT_FOUND;
                end
            end
            slir_pkg::OP_READ: begin
                if ((32'(i_position) < 32'(r_count)) && (32'(i_position) < 32'(N))) begin
                    for (int i = 0; i < N; i++) begin
                        if (32'(i_position) == 32'(i)) begin
                            n_read_value = val[i];
                        end
                    end
                end else begin
                    n_status = slir_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_status = slir_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = 5'(r_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(N))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == slir_pkg::OP_INSERT) && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == slir_pkg::OP_REMOVE) && !found)
        |=> ($stable(r_count) && (r_status == slir_pkg::ST_NOT_FOUND)))
        else $error("remove miss changed the list");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule

[bench/sorted_list_insert_remove_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted list: directed corner cases, then random traffic.
module sorted_list_insert_remove_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         MAX_REPORTS = 10;
    localparam int         POOL_SIZE   = 12;

    typedef struct packed {
        slir_pkg::t_status                status;
        logic signed [slir_pkg::VAL_W-1:0] read_value;
        logic [4:0]                       entry_count;
    } t_list_result;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_ready;
    logic [1:0]                        i_opcode     = slir_pkg::OP_INSERT;
    logic signed [slir_pkg::VAL_W-1:0] i_value      = '0;
    logic [3:0]                        i_position   = '0;
    logic                              o_out_valid;
    logic                              i_out_ready  = 1'b0;
    logic [1:0]                        o_status;
    logic signed [slir_pkg::VAL_W-1:0] o_read_value;
    logic [4:0]                        o_entry_count;

    logic signed [slir_pkg::VAL_W-1:0] held_entries [slir_pkg::CAPACITY];
    int                                held_total     = 0;
    t_list_result                      pending_results [$];
    logic signed [slir_pkg::VAL_W-1:0] value_pool [POOL_SIZE];
    int                                mismatch_count = 0;
    int                                idle_cycles    = 0;
    int                                out_stall_left = 0;
    bit                                in_gaps_on     = 1'b0;
    bit                                out_stalls_on  = 1'b0;

    sorted_list_insert_remove DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_list_result apply_to_sorted_copy(
        input logic [1:0]                        op,
        input logic signed [slir_pkg::VAL_W-1:0] val,
        input logic [3:0]                        pos
    );
        t_list_result res;
        int           at;
        int           i;
        res.status     = slir_pkg::ST_OK;
        res.read_value = '0;
        case (op)
            slir_pkg::OP_INSERT: begin
                if (held_total >= slir_pkg::CAPACITY) begin
                    res.status = slir_pkg::ST_FULL;
                end else begin
                    at = 0;
                    while (at < held_total && held_entries[at] < val) at++;
                    for (i = held_total; i > at; i--) held_entries[i] = held_entries[i - 1];
                    held_entries[at] = val;
                    held_total++;
                end
            end
            slir_pkg::OP_REMOVE: begin
                at = 0;
                while (at < held_total && held_entries[at] !== val) at++;
                if (at >= held_total) begin
                    res.status = slir_pkg::ST_NOT_FOUND;
                end else begin
                    for (i = at; i + 1 < held_total; i++) held_entries[i] = held_entries[i + 1];
                    held_total--;
                end
            end
            slir_pkg::OP_READ: begin
                if (int'(pos) < held_total) begin
                    res.read_value = held_entries[pos];
                end else begin
                    res.status = slir_pkg::ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = 5'(held_total);
        return res;
    endfunction

    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 4);
    endfunction

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf(
                        "result with none pending: status %0d value %0d count %0d",
                        o_status, o_read_value, o_entry_count));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_read_value !== want.read_value ||
                        o_entry_count !== want.entry_count) begin
                        note_failure($sformatf(
                            "mismatch: status %0d/%0d value %0d/%0d count %0d/%0d (exp/act)",
                            want.status, o_status, want.read_value, o_read_value,
                            want.entry_count, o_entry_count));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(apply_to_sorted_copy(i_opcode, i_value, i_position));
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_ready <= 1'b0;
        end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
            out_stall_left = pick_idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[sorted_list_insert_remove] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op,
                             input logic signed [slir_pkg::VAL_W-1:0] val,
                             input logic [3:0] pos);
        int gap;
        if (in_gaps_on && $urandom_range(0, 2) == 0) begin
            gap = pick_idle_len();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic refresh_value_pool();
        int k;
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (k = 4; k < POOL_SIZE; k++) begin
            if (k < 8) begin
                value_pool[k] = int'($urandom_range(0, 20)) - 10;
            end else begin
                value_pool[k] = $urandom;
            end
        end
    endtask

    task automatic send_random_item(input int insert_pct, input int remove_pct);
        int                                pick;
        logic [1:0]                        op;
        logic signed [slir_pkg::VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) begin
            op = slir_pkg::OP_INSERT;
        end else if (pick < insert_pct + remove_pct) begin
            op = slir_pkg::OP_REMOVE;
        end else if (pick < 95) begin
            op = slir_pkg::OP_READ;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(0, 3) == 0) begin
            val = $urandom;
        end else begin
            val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        send_item(op, val, 4'($urandom_range(0, 15)));
    endtask

    task automatic test_empty_list();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        send_item(slir_pkg::OP_READ, 0, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd15);
        send_item(slir_pkg::OP_REMOVE, 0, 4'd0);
        send_item(slir_pkg::OP_REMOVE, 32'sh8000_0000, 4'd0);
        send_item(OP_UNUSED, -1, 4'd15);
    endtask

    task automatic test_extremes_and_order();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        send_item(slir_pkg::OP_INSERT, 0, 4'd0);
        send_item(slir_pkg::OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
        send_item(slir_pkg::OP_INSERT, 32'sh8000_0000, 4'd0);
        send_item(slir_pkg::OP_INSERT, -1, 4'd0);
        send_item(slir_pkg::OP_INSERT, 0, 4'd0);
        send_item(slir_pkg::OP_INSERT, 1, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd2);
        send_item(slir_pkg::OP_READ, 0, 4'd5);
        send_item(slir_pkg::OP_REMOVE, 0, 4'd0);
        send_item(slir_pkg::OP_REMOVE, 12345, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd5);
        send_item(OP_UNUSED, 32'sh5555_AAAA, 4'd10);
    endtask

    task automatic test_fill_to_full();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b1;
        repeat (11) send_item(slir_pkg::OP_INSERT, $urandom, 4'($urandom_range(0, 15)));
        send_item(slir_pkg::OP_INSERT, 7, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd15);
        send_item(slir_pkg::OP_REMOVE, 32'sh8000_0000, 4'd0);
        send_item(slir_pkg::OP_INSERT, 32'sh8000_0000, 4'd0);
        send_item(slir_pkg::OP_READ, 0, 4'd0);
    endtask

    task automatic test_random_fill_drain();
        int round;
        for (round = 0; round < 8; round++) begin
            in_gaps_on    = round[0];
            out_stalls_on = round[1];
            refresh_value_pool();
            repeat (50) send_random_item(65, 15);
            repeat (50) send_random_item(15, 65);
        end
    endtask

    task automatic test_random_mixed();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        refresh_value_pool();
        repeat (150) send_random_item(40, 35);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_extremes_and_order();
        test_fill_to_full();
        test_random_fill_drain();
        test_random_mixed();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[sorted_list_insert_remove] OK");
        end else begin
            $display("[sorted_list_insert_remove] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/slir_pkg.sv
rtl/slir_cell.sv
rtl/sorted_list_insert_remove.sv
bench/sorted_list_insert_remove_tb.sv
